// ===== hdl/swsc_pkg.sv =====
// types and constants shared by the sliding window sender control block
package swsc_pkg;

    localparam int SEQ_W   = 32;
    localparam int SLOT_W  = 3;
    localparam int TMR_W   = 16;
    localparam int RUN_LEN = 8;
    localparam int RUN_W   = 3;

    localparam logic [TMR_W-1:0] TIMEOUT_RST = 16'd1000;
    localparam logic [SEQ_W-1:0] SEQ_RST     = 32'd1;

    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_ACK  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    typedef enum logic [1:0] {
        KIND_SEND      = 2'd0,
        KIND_RESEND    = 2'd1,
        KIND_WIN_DONE  = 2'd2,
        KIND_XFER_DONE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_FILL,
        PH_WAIT,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACK,
        ST_EMIT,
        ST_RSND
    } t_state;

    typedef struct packed {
        logic [1:0]       cmd;
        logic             end_of_file;
        logic             is_ack;
        logic [SEQ_W-1:0] ack_number;
    } t_in_item;

    typedef struct packed {
        t_kind             kind;
        logic [SLOT_W-1:0] slot;
        logic [SEQ_W-1:0]  seq_num;
        logic              is_fin;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic             fin;
    } t_slot_entry;

endpackage

// ===== hdl/swsc_slot_mem.sv =====
// slot memory: sequence number and fin flag per window slot, registered read
module swsc_slot_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  swsc_pkg::t_slot_entry i_wr_data,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output swsc_pkg::t_slot_entry o_rd_data
);
    import swsc_pkg::*;

    t_slot_entry r_mem [DEPTH];
    t_slot_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/swsc_ctrl.sv =====
// window controller: phase, counters, timer and write and read sequencing of the slot memory
module swsc_ctrl #(
    parameter int WINDOW = 8,
    parameter int IW     = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [15:0]           i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  swsc_pkg::t_in_item    i_in,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output swsc_pkg::t_out_item   o_res,
    output logic                  o_mem_wr_en,
    output logic [IW-1:0]         o_mem_wr_addr,
    output swsc_pkg::t_slot_entry o_mem_wr_data,
    output logic                  o_mem_rd_en,
    output logic [IW-1:0]         o_mem_rd_addr,
    input  swsc_pkg::t_slot_entry i_mem_rd_data
);
    import swsc_pkg::*;

    localparam int CW = $clog2(WINDOW + 1);

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [SEQ_W-1:0]  r_base, n_base;
    logic [SEQ_W-1:0]  r_next_seq, n_next_seq;
    logic [CW-1:0]     r_fill, n_fill;
    logic [CW-1:0]     r_acked, n_acked;
    logic [1:0]        r_dup, n_dup;
    logic              r_file_ended, n_file_ended;
    logic [TMR_W-1:0]  r_tmr_cnt, n_tmr_cnt;
    logic              r_tmr_run, n_tmr_run;
    logic [TMR_W-1:0]  r_timeout;
    logic [SEQ_W-1:0]  r_ack, n_ack;
    t_out_item         r_res, n_res;
    logic [IW-1:0]     r_idx, n_idx;
    logic [RUN_W-1:0]  r_run_cnt, n_run_cnt;

    logic              in_acc;
    logic              live;
    logic              send_go;
    logic              send_fin;
    logic              ack_go;
    logic              ack_fin;
    logic              tick_go;
    logic [TMR_W-1:0]  tmr_inc;
    logic [TMR_W-1:0]  tmr_limit;
    logic              tmr_fire;
    logic              tick_run;
    logic              dup;
    logic              dup_run;
    logic [SEQ_W-1:0]  ack_diff;
    logic              ack_full;
    logic              res_acc;
    logic              run_last;

    assign in_acc    = i_in_valid & o_in_ready;
    assign live      = in_acc && (r_phase != PH_DONE);
    assign send_go   = live && (i_in.cmd == CMD_SEND) && (r_phase == PH_FILL)
                       && (r_fill < CW'(WINDOW));
    assign send_fin  = r_file_ended | i_in.end_of_file;
    assign ack_go    = live && (i_in.cmd == CMD_ACK) && (r_phase == PH_WAIT) && i_in.is_ack;
    assign ack_fin   = r_file_ended && (i_in.ack_number >= (r_next_seq - SEQ_W'(1)));
    assign tick_go   = live && (i_in.cmd == CMD_TICK) && r_tmr_run;
    assign tmr_inc   = r_tmr_cnt + TMR_W'(1);
    assign tmr_limit = (r_timeout == '0) ? TMR_W'(1) : r_timeout;
    assign tmr_fire  = tmr_inc >= tmr_limit;
    assign tick_run  = tick_go && tmr_fire && (r_phase == PH_WAIT);
    assign dup       = i_mem_rd_data.seq > r_ack;
    assign dup_run   = dup && (r_dup == 2'd2);
    assign ack_diff  = r_ack - r_base;
    assign ack_full  = ack_diff >= SEQ_W'(WINDOW - 1);
    assign res_acc   = o_res_valid & i_res_ready;
    assign run_last  = (r_idx == IW'(WINDOW - 1)) || (r_run_cnt == RUN_W'(RUN_LEN - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (send_go) begin
                    n_state = ST_EMIT;
                end else if (ack_go) begin
                    n_state = ack_fin ? ST_EMIT : ST_ACK;
                end else if (tick_run) begin
                    n_state = ST_RSND;
                end
            end
            ST_ACK: begin
                if (dup) begin
                    n_state = dup_run ? ST_RSND : ST_IDLE;
                end else begin
                    n_state = ack_full ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (res_acc) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RSND: begin
                if (res_acc && run_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_phase      = r_phase;
        n_base       = r_base;
        n_next_seq   = r_next_seq;
        n_fill       = r_fill;
        n_acked      = r_acked;
        n_dup        = r_dup;
        n_file_ended = r_file_ended;
        n_tmr_cnt    = r_tmr_cnt;
        n_tmr_run    = r_tmr_run;
        n_ack        = r_ack;
        n_res        = r_res;
        n_idx        = r_idx;
        n_run_cnt    = r_run_cnt;
        case (r_state)
            ST_IDLE: begin
                if (send_go) begin
                    n_file_ended  = send_fin;
                    n_res.kind    = KIND_SEND;
                    n_res.slot    = SLOT_W'(r_fill);
                    n_res.seq_num = r_next_seq;
                    n_res.is_fin  = send_fin;
                    n_res.last    = 1'b1;
                    if (r_base == r_next_seq) begin
                        n_tmr_cnt = '0;
                        n_tmr_run = 1'b1;
                    end
                    if (!send_fin) begin
                        n_next_seq = r_next_seq + SEQ_W'(1);
                    end
                    n_fill = r_fill + CW'(1);
                    if (r_fill == CW'(WINDOW - 1)) begin
                        n_phase = PH_WAIT;
                        n_acked = '0;
                        n_dup   = '0;
                    end
                end else if (ack_go) begin
                    n_ack = i_in.ack_number;
                    if (ack_fin) begin
                        n_phase       = PH_DONE;
                        n_res.kind    = KIND_XFER_DONE;
                        n_res.slot    = '0;
                        n_res.seq_num = '0;
                        n_res.is_fin  = 1'b0;
                        n_res.last    = 1'b1;
                        n_tmr_run     = 1'b0;
                        n_tmr_cnt     = '0;
                    end
                end else if (tick_go) begin
                    n_tmr_cnt = tmr_fire ? '0 : tmr_inc;
                    if (tick_run) begin
                        n_idx     = r_acked[IW-1:0];
                        n_run_cnt = '0;
                    end
                end
            end
            ST_ACK: begin
                if (dup) begin
                    if (r_dup != 2'd3) begin
                        n_dup = r_dup + 2'd1;
                    end
                    if (dup_run) begin
                        n_idx     = r_acked[IW-1:0];
                        n_run_cnt = '0;
                        n_tmr_cnt = '0;
                        n_tmr_run = 1'b1;
                    end
                end else begin
                    n_dup = '0;
                    if (ack_full) begin
                        n_base        = r_base + SEQ_W'(WINDOW);
                        n_res.slot    = '0;
                        n_res.seq_num = '0;
                        n_res.is_fin  = 1'b0;
                        n_res.last    = 1'b1;
                        n_tmr_run     = 1'b0;
                        n_tmr_cnt     = '0;
                        if (r_file_ended) begin
                            n_phase    = PH_DONE;
                            n_res.kind = KIND_XFER_DONE;
                            n_acked    = CW'(WINDOW);
                        end else begin
                            n_phase    = PH_FILL;
                            n_res.kind = KIND_WIN_DONE;
                            n_fill     = '0;
                            n_acked    = '0;
                            n_next_seq = r_base + SEQ_W'(WINDOW);
                        end
                    end else begin
                        n_acked = CW'(ack_diff) + CW'(1);
                    end
                end
            end
            ST_RSND: begin
                if (res_acc && !run_last) begin
                    n_idx     = r_idx + IW'(1);
                    n_run_cnt = r_run_cnt + RUN_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready     = (r_state == ST_IDLE);
        o_res_valid    = (r_state == ST_EMIT) || (r_state == ST_RSND);
        o_res          = r_res;
        if (r_state == ST_RSND) begin
            o_res.kind    = KIND_RESEND;
            o_res.slot    = SLOT_W'(r_idx);
            o_res.seq_num = i_mem_rd_data.seq;
            o_res.is_fin  = i_mem_rd_data.fin;
            o_res.last    = run_last;
        end
        o_mem_wr_en       = send_go;
        o_mem_wr_addr     = r_fill[IW-1:0];
        o_mem_wr_data.seq = r_next_seq;
        o_mem_wr_data.fin = send_fin;
        o_mem_rd_en       = (ack_go && !ack_fin) || tick_run
                            || ((r_state == ST_ACK) && dup_run)
                            || ((r_state == ST_RSND) && res_acc && !run_last);
        o_mem_rd_addr     = (r_state == ST_RSND) ? (r_idx + IW'(1)) : r_acked[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= PH_FILL;
            r_base       <= SEQ_RST;
            r_next_seq   <= SEQ_RST;
            r_fill       <= '0;
            r_acked      <= '0;
            r_dup        <= '0;
            r_file_ended <= 1'b0;
            r_tmr_cnt    <= '0;
            r_tmr_run    <= 1'b0;
            r_idx        <= '0;
            r_run_cnt    <= '0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_base       <= n_base;
            r_next_seq   <= n_next_seq;
            r_fill       <= n_fill;
            r_acked      <= n_acked;
            r_dup        <= n_dup;
            r_file_ended <= n_file_ended;
            r_tmr_cnt    <= n_tmr_cnt;
            r_tmr_run    <= n_tmr_run;
            r_idx        <= n_idx;
            r_run_cnt    <= n_run_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ack <= n_ack;
        r_res <= n_res;
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(WINDOW))
        else $error("fill slot beyond window");

    a_wait_acked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WAIT) |-> (r_acked < CW'(WINDOW)))
        else $error("acked slot out of range while waiting");

    a_wr_only_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_wr_en |-> ((r_phase == PH_FILL) && !o_mem_rd_en))
        else $error("slot write outside filling or overlapping a read");

    a_rsnd_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RSND) |-> (r_phase == PH_WAIT))
        else $error("resend run outside ack phase");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |=> (r_phase == PH_DONE))
        else $error("left done phase");

endmodule

// ===== hdl/sliding_window_sender_control.sv =====
// top level: sliding window sender control with slot memory and output register
// send: result is registered in the controller, then moved into the output register when it has room
// ack: slot memory read, then decision; an ack that covers the fin emits the done result without the read
// resend run: on a tick or third duplicate ack; one result per cycle unless output is full
// one item at a time: no new input is taken until the last item's results have left the controller,
// so a full output register also holds back the input
// reset: synchronous active low, clears control state; slot memory is not cleared
module sliding_window_sender_control #(
    parameter int WINDOW = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  swsc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output swsc_pkg::t_out_item o_out_data
);
    import swsc_pkg::*;

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic          res_valid;
    logic          res_ready;
    t_out_item     res;
    logic          mem_wr_en;
    logic [IW-1:0] mem_wr_addr;
    t_slot_entry   mem_wr_data;
    logic          mem_rd_en;
    logic [IW-1:0] mem_rd_addr;
    t_slot_entry   mem_rd_data;

    logic          r_out_valid;
    t_out_item     r_out;

    swsc_ctrl #(
        .WINDOW (WINDOW),
        .IW     (IW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in          (i_in_data),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res),
        .o_mem_wr_en   (mem_wr_en),
        .o_mem_wr_addr (mem_wr_addr),
        .o_mem_wr_data (mem_wr_data),
        .o_mem_rd_en   (mem_rd_en),
        .o_mem_rd_addr (mem_rd_addr),
        .i_mem_rd_data (mem_rd_data)
    );

    swsc_slot_mem #(
        .DEPTH (WINDOW),
        .AW    (IW)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // output register takes a new result when empty or being drained
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
